FILE: design/sphere_texcoord_from_position_defines.svh
// Assertion macros for the texture coordinate block
`ifndef SPHERE_TEXCOORD_FROM_POSITION_DEFINES_SVH
`define SPHERE_TEXCOORD_FROM_POSITION_DEFINES_SVH

`ifndef SYNTHESIS
`define STC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("stc assertion failed");
`define STC_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("stc forbidden condition");
`else
`define STC_ASSERT(lbl, prop)
`define STC_NEVER(lbl, expr)
`endif

`endif

FILE: design/stc_pkg.sv
package stc_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int TEX_WIDTH    = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 24;

  localparam logic [TEX_WIDTH-1:0] TEX_HALF = 16'h8000;
  localparam logic [TEX_WIDTH-1:0] TEX_MAX  = 16'hFFFF;
  localparam logic [47:0]          SQRT_BIT0 = 48'h4000_0000_0000;

  // one lane of the square root chain
  typedef struct packed {
    logic [47:0] rem;
    logic [47:0] root;
    logic [23:0] mag;
    logic        neg;
    logic        czero;
    logic        szero;
  } sq_lane_t;

  typedef struct packed {
    sq_lane_t    u;
    sq_lane_t    v;
    logic [47:0] bitv;
  } sq_word_t;

  // one lane of the rotation chain
  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [33:0] z;
    logic               neg;
    logic               czero;
    logic               szero;
  } cd_lane_t;

  typedef struct packed {
    cd_lane_t   u;
    cd_lane_t   v;
    logic [4:0] step;
  } cd_word_t;

  // atan(2^-i), pi = 2^32
  function automatic logic signed [33:0] atan_val(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd1073741824;
      5'd1:  r = 34'sd633866811;
      5'd2:  r = 34'sd334917815;
      5'd3:  r = 34'sd170009513;
      5'd4:  r = 34'sd85334662;
      5'd5:  r = 34'sd42708930;
      5'd6:  r = 34'sd21359676;
      5'd7:  r = 34'sd10680490;
      5'd8:  r = 34'sd5340327;
      5'd9:  r = 34'sd2670173;
      5'd10: r = 34'sd1335088;
      5'd11: r = 34'sd667544;
      5'd12: r = 34'sd333772;
      5'd13: r = 34'sd166886;
      5'd14: r = 34'sd83443;
      5'd15: r = 34'sd41722;
      5'd16: r = 34'sd20861;
      5'd17: r = 34'sd10430;
      5'd18: r = 34'sd5215;
      5'd19: r = 34'sd2608;
      5'd20: r = 34'sd1304;
      5'd21: r = 34'sd652;
      5'd22: r = 34'sd326;
      5'd23: r = 34'sd163;
      5'd24: r = 34'sd81;
      5'd25: r = 34'sd41;
      5'd26: r = 34'sd20;
      5'd27: r = 34'sd10;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

endpackage

FILE: design/stc_sqrt_cell.sv
module stc_sqrt_cell import stc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_vld_i,
  output logic     in_rdy_o,
  input  sq_word_t in_word_i,
  output logic     out_vld_o,
  input  logic     out_rdy_i,
  output sq_word_t out_word_o
);

  logic     vld_q;
  sq_word_t word_q, word_d;

  // one restoring root step for one lane
  function automatic sq_lane_t step(input sq_lane_t l, input logic [47:0] bitv);
    sq_lane_t    r;
    logic [47:0] t;
    r = l;
    t = l.root + bitv;
    if (l.rem >= t) begin
      r.rem  = l.rem - t;
      r.root = (l.root >> 1) + bitv;
    end else begin
      r.root = l.root >> 1;
    end
    return r;
  endfunction

  assign in_rdy_o = !vld_q || out_rdy_i;

  always_comb begin
    word_d      = in_word_i;
    word_d.u    = step(in_word_i.u, in_word_i.bitv);
    word_d.v    = step(in_word_i.v, in_word_i.bitv);
    word_d.bitv = in_word_i.bitv >> 2;
  end

  // advance when the neighbor takes the word or the slot is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      word_q <= word_d;
    end
  end

  assign out_vld_o  = vld_q;
  assign out_word_o = word_q;

endmodule

FILE: design/stc_cordic_cell.sv
module stc_cordic_cell import stc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_vld_i,
  output logic     in_rdy_o,
  input  cd_word_t in_word_i,
  output logic     out_vld_o,
  input  logic     out_rdy_i,
  output cd_word_t out_word_o
);

  logic     vld_q;
  cd_word_t word_q, word_d;

  // one vectoring rotation for one lane
  function automatic cd_lane_t rot(input cd_lane_t l, input logic [4:0] i);
    cd_lane_t r;
    r = l;
    if (l.b >= 0) begin
      r.a = l.a + (l.b >>> i);
      r.b = l.b - (l.a >>> i);
      r.z = l.z + atan_val(i);
    end else begin
      r.a = l.a - (l.b >>> i);
      r.b = l.b + (l.a >>> i);
      r.z = l.z - atan_val(i);
    end
    return r;
  endfunction

  assign in_rdy_o = !vld_q || out_rdy_i;

  always_comb begin
    word_d      = in_word_i;
    word_d.u    = rot(in_word_i.u, in_word_i.step);
    word_d.v    = rot(in_word_i.v, in_word_i.step);
    word_d.step = in_word_i.step + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_rdy_o) begin
      vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy_o && in_vld_i) begin
      word_q <= word_d;
    end
  end

  assign out_vld_o  = vld_q;
  assign out_word_o = word_q;

endmodule

FILE: design/sphere_texcoord_from_position.sv
// Channel  Dir  tdata fields (low bit up)           Accept
// s_axis   in   pos_x[15:0] pos_y[31:16] pos_z[47:32]  tvalid && tready
// m_axis   out  tex_u[15:0] tex_v[31:16]             tvalid && tready
//
// One position per cycle enters while the output is not stalled.
// The path is one square stage, 24 root cells, 28 rotation cells, one output.
// Every cell holds one word; a stall at the output backs up cell by cell,
// and the input stays ready while any cell is empty.
// Reset clears all valid flags; no clearing pass.
`include "sphere_texcoord_from_position_defines.svh"
module sphere_texcoord_from_position import stc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pos_x, pos_y, pos_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // tex_u, tex_v
);

  logic               a_vld_q;
  logic signed [15:0] x_q, y_q;
  logic [30:0]        xx_q, yy_q, zz_q;

  logic     sq_vld [0:SQRT_STEPS];
  logic     sq_rdy [0:SQRT_STEPS];
  sq_word_t sq_w   [0:SQRT_STEPS];
  logic     cd_vld [0:CORDIC_STEPS];
  logic     cd_rdy [0:CORDIC_STEPS];
  cd_word_t cd_w   [0:CORDIC_STEPS];

  logic        o_vld_q;
  logic        o_rdy;
  logic        o_load;
  cd_word_t    o_w;
  logic [31:0] o_data_q, o_data_d;

  // square the coordinates
  assign s_axis_tready = !a_vld_q || sq_rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      x_q  <= $signed(s_axis_tdata[15:0]);
      y_q  <= $signed(s_axis_tdata[31:16]);
      xx_q <= 31'($signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[15:0]));
      yy_q <= 31'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]));
      zz_q <= 31'($signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]));
    end
  end

  function automatic sq_lane_t lane_init(input logic signed [15:0] c,
                                         input logic [30:0] p, input logic [30:0] q);
    sq_lane_t    l;
    logic [31:0] s;
    logic [15:0] m;
    s       = {1'b0, p} + {1'b0, q};
    m       = c[15] ? 16'(-c) : 16'(c);
    l.rem   = {s, 16'h0};
    l.root  = '0;
    l.mag   = {m, 8'h0};
    l.neg   = c[15];
    l.czero = (c == 16'sd0);
    l.szero = (s == 32'd0);
    return l;
  endfunction

  // sum and scale the other two squares into the root chain
  assign sq_vld[0]    = a_vld_q;
  assign sq_w[0].u    = lane_init(x_q, yy_q, zz_q);
  assign sq_w[0].v    = lane_init(y_q, xx_q, zz_q);
  assign sq_w[0].bitv = SQRT_BIT0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    stc_sqrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (sq_vld[i]),
      .in_rdy_o  (sq_rdy[i]),
      .in_word_i (sq_w[i]),
      .out_vld_o (sq_vld[i+1]),
      .out_rdy_i (sq_rdy[i+1]),
      .out_word_o(sq_w[i+1])
    );
  end

  function automatic cd_lane_t cd_init(input sq_lane_t l);
    cd_lane_t r;
    r.a     = $signed(l.root[31:0]);
    r.b     = $signed({8'h0, l.mag});
    r.z     = '0;
    r.neg   = l.neg;
    r.czero = l.czero;
    r.szero = l.szero;
    return r;
  endfunction

  // hand root and magnitude to the rotation chain
  assign cd_vld[0]           = sq_vld[SQRT_STEPS];
  assign sq_rdy[SQRT_STEPS]  = cd_rdy[0];
  assign cd_w[0].u           = cd_init(sq_w[SQRT_STEPS].u);
  assign cd_w[0].v           = cd_init(sq_w[SQRT_STEPS].v);
  assign cd_w[0].step        = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    stc_cordic_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .in_vld_i  (cd_vld[i]),
      .in_rdy_o  (cd_rdy[i]),
      .in_word_i (cd_w[i]),
      .out_vld_o (cd_vld[i+1]),
      .out_rdy_i (cd_rdy[i+1]),
      .out_word_o(cd_w[i+1])
    );
  end

  function automatic logic [15:0] tex_of(input cd_lane_t l);
    logic signed [33:0] zc;
    logic [32:0]        rnd;
    logic [15:0]        ang;
    logic [16:0]        sum;
    logic [15:0]        r;
    if (l.z < 0) begin
      zc = '0;
    end else if (l.z > 34'sd2147483648) begin
      zc = 34'sd2147483648;
    end else begin
      zc = l.z;
    end
    rnd = zc[32:0] + 33'd32768;
    ang = l.szero ? TEX_HALF : rnd[31:16];
    if (ang > TEX_HALF) begin
      ang = TEX_HALF;
    end
    sum = {1'b0, TEX_HALF} + {1'b0, ang};
    if (l.czero) begin
      r = TEX_HALF;
    end else if (!l.neg) begin
      r = sum[16] ? TEX_MAX : sum[15:0];
    end else begin
      r = TEX_HALF - ang;
    end
    return r;
  endfunction

  // round, saturate and hold the result word
  assign o_rdy                = !o_vld_q || m_axis_tready;
  assign cd_rdy[CORDIC_STEPS] = o_rdy;
  assign o_w                  = cd_w[CORDIC_STEPS];
  assign o_load               = o_rdy && cd_vld[CORDIC_STEPS];
  assign o_data_d = {tex_of(o_w.v), tex_of(o_w.u)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (o_rdy) begin
      o_vld_q <= cd_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_load) begin
      o_data_q <= o_data_d;
    end
  end

  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_data_q;

  `STC_NEVER(a_full_when_blocked, !s_axis_tready && !(o_vld_q && !m_axis_tready))
  `STC_ASSERT(a_zero_gives_half, (o_load && o_w.u.czero) |=> (o_data_q[15:0] == TEX_HALF))
  `STC_ASSERT(a_neg_below_half, (o_load && o_w.v.neg) |=> (o_data_q[31:16] <= TEX_HALF))

endmodule

FILE: sim/tb_sphere_texcoord_from_position.sv
`timescale 1ns / 100ps
module tb_sphere_texcoord_from_position;
  import stc_pkg::*;

  localparam int      NUM_RANDOM = 1950;
  localparam int      LATENCY    = 54;
  localparam longint  CYCLE_MAX  = 400000;

  typedef struct packed {
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } position_t;

  typedef struct packed {
    logic [15:0] tex_v;
    logic [15:0] tex_u;
  } texcoord_t;

  // atan(2^-i), pi = 2^32
  localparam longint ATAN_STEP [28] = '{
    1073741824, 633866811, 334917815, 170009513, 85334662, 42708930,
    21359676, 10680490, 5340327, 2670173, 1335088, 667544,
    333772, 166886, 83443, 41722, 20861, 10430,
    5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // pos_x, pos_y, pos_z
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // tex_u, tex_v

  position_t   pending_positions[$];
  texcoord_t   expected_texcoords[$];
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_sender;
  int          error_count;
  int          texcoord_count;
  longint      cycle_count;
  bit          stim_done;

  sphere_texcoord_from_position u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // floor square root, bit by bit
  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // texture coordinate of c against the other two coordinates d and e
  function automatic logic [15:0] sphere_coord(input longint c, input longint d,
                                               input longint e);
    longint unsigned mag, sumsq, ang;
    longint a, b, z, na, nb;
    if (c == 0) return TEX_HALF;
    mag   = (c < 0) ? -c : c;
    sumsq = d * d + e * e;
    if (sumsq == 0) begin
      ang = 64'd1 << 31;
    end else begin
      // shift by 2*E and E with E = 8 at 16-bit coordinates
      a = floor_sqrt(sumsq << 16);
      b = mag << 8;
      z = 0;
      for (int i = 0; i < 28; i++) begin
        if (b >= 0) begin
          na = a + (b >>> i);
          nb = b - (a >>> i);
          z += ATAN_STEP[i];
        end else begin
          na = a - (b >>> i);
          nb = b + (a >>> i);
          z -= ATAN_STEP[i];
        end
        a = na;
        b = nb;
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
      ang = z;
    end
    ang = (ang + (64'd1 << 15)) >> 16;
    if (ang > TEX_HALF) ang = TEX_HALF;
    if (c > 0) return (TEX_HALF + ang > TEX_MAX) ? TEX_MAX : TEX_HALF + ang;
    return TEX_HALF - ang;
  endfunction

  function automatic texcoord_t texcoord_of(input position_t p);
    texcoord_t t;
    longint x, y, z;
    x = $signed(p.pos_x);
    y = $signed(p.pos_y);
    z = $signed(p.pos_z);
    t.tex_u = sphere_coord(x, y, z);
    t.tex_v = sphere_coord(y, x, z);
    return t;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 15) - 8;
      1:       return $urandom_range(0, 1) ? 16'h7FFF - $urandom_range(0, 3)
                                           : 16'h8000 + $urandom_range(0, 3);
      2:       return 16'h0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_position(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
    pending_positions.push_back({z, y, x});
  endtask

  // drive input words; advance on accept
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_texcoords.push_back(texcoord_of(s_axis_tdata));
        void'(pending_positions.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word
      end else if (pending_positions.size() > 0
                   && !hold_sender && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_positions[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // check output words against the oldest expected texcoord
  always @(posedge clk_i or negedge rst_ni) begin
    texcoord_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        texcoord_count <= texcoord_count + 1;
        if (expected_texcoords.size() == 0) begin
          $error("unexpected word tex_u=%0d tex_v=%0d", got.tex_u, got.tex_v);
          error_count++;
        end else begin
          want = expected_texcoords.pop_front();
          if (got.tex_u !== want.tex_u) begin
            $error("tex_u: expected %0d, actual %0d", want.tex_u, got.tex_u);
            error_count++;
          end
          if (got.tex_v !== want.tex_v) begin
            $error("tex_v: expected %0d, actual %0d", want.tex_v, got.tex_v);
            error_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // stop a hung run
  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_sphere_texcoord_from_position: done, errors");
      $finish;
    end
  end

  initial begin
    logic [15:0] r;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_sender    = 1'b0;
    error_count    = 0;
    texcoord_count = 0;
    cycle_count    = 0;
    stim_done      = 1'b0;
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: zero vector, axes, extremes, sign pairs, 1.0
    push_position(16'h0000, 16'h0000, 16'h0000);
    push_position(16'h1000, 16'h0000, 16'h0000);
    push_position(16'hF000, 16'h0000, 16'h0000);
    push_position(16'h0000, 16'h1000, 16'h0000);
    push_position(16'h0000, 16'hF000, 16'h0000);
    push_position(16'h0000, 16'h0000, 16'h7FFF);
    push_position(16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_position(16'h8000, 16'h8000, 16'h8000);
    push_position(16'h7FFF, 16'h8000, 16'h0001);
    push_position(16'h8000, 16'h7FFF, 16'hFFFF);
    push_position(16'h0001, 16'h0001, 16'h7FFF);
    push_position(16'hFFFF, 16'hFFFF, 16'h8000);
    push_position(16'h1000, 16'h1000, 16'h1000);
    push_position(16'hF000, 16'hF000, 16'hF000);
    push_position(16'h0001, 16'hFFFF, 16'h0000);
    push_position(16'h8000, 16'h0000, 16'h0001);
    push_position(16'h7FFF, 16'h0001, 16'h0000);
    push_position(16'hAAAA, 16'h5555, 16'hAAAA);
    push_position(16'h5555, 16'hAAAA, 16'h5555);
    wait (pending_positions.size() == 0);

    // pause the sender until every texcoord is back
    hold_sender = 1'b1;
    wait (expected_texcoords.size() == 0);
    hold_sender = 1'b0;

    // random phases with varied idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3: begin send_idle_pct = 14; recv_stall_pct = 14; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < NUM_RANDOM / 5; i++)
        push_position(rand_coord(), rand_coord(), rand_coord());
      wait (pending_positions.size() == 0);
    end
    stim_done = 1'b1;

    // drain
    wait (expected_texcoords.size() == 0);
    recv_stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("covered %0d texcoords: axes, zero vector, extremes, random positions",
             texcoord_count);
    $display("idle phases: none, sender 56%%, receiver 56%%, both 14%%");
    if (error_count == 0 && expected_texcoords.size() == 0) begin
      $display("tb_sphere_texcoord_from_position: done, clean");
    end else begin
      $display("tb_sphere_texcoord_from_position: done, errors");
    end
    $finish;
  end

endmodule
